/* hw/rtl/dtkf_pkg.sv */
// shared types and constants for the decimal text to two-byte float encoder
`default_nettype none

package dtkf_pkg;

  localparam int DTKF_ACC_BITS = 27;

  localparam int MANT_BITS = 11;
  localparam int EXP_BITS  = 4;

  localparam logic [MANT_BITS-1:0] MANT_MAX  = 11'h7FF;
  localparam logic [MANT_BITS:0]   NEG_BASE  = 12'h800;
  localparam logic [EXP_BITS-1:0]  EXP_TOP   = 4'hF;
  // shift counter has one extra bit to see the overflow step
  localparam logic [EXP_BITS:0]    EXP_LIMIT = 5'd15;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } dtkf_in_t;

  typedef struct packed {
    logic [15:0] float_word;
    logic        out_of_range;
  } dtkf_out_t;

  typedef struct packed {
    logic take;
    logic pad;
    logic shift;
    logic load_out;
    logic clear;
  } dtkf_cmd_t;

  typedef struct packed {
    logic pad_more;
    logic norm_more;
    logic out_free;
  } dtkf_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/decimal_text_to_knx_float16.sv */
// top level: decimal text to two-byte float encoder
//
// in channel: one ASCII character per request (in_data.text_char), sign first,
// in_data.is_last marks the final character of a value. Characters other than
// the last are taken one per cycle with no stall.
// out channel: one request per value, in_data.is_last triggers it, carrying the
// 16-bit sign/exponent/mantissa word and the out_of_range flag.
// after the last character the input stalls while the controller pads missing
// fraction digits with zeros, shifts the magnitude right one bit per cycle until
// it fits 11 bits or the exponent passes 15, then loads the output register.
// the output register holds its request while out_stall is high; the next
// value is still taken in full, then its result waits with the input stalled.
// rst_n (synchronous, active low) clears the parser and drops out_valid.
`default_nettype none

module decimal_text_to_knx_float16 import dtkf_pkg::*; #(
  parameter int ACC_BITS = DTKF_ACC_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dtkf_in_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output dtkf_out_t     out_data
);

  dtkf_cmd_t cmd;
  dtkf_sts_t sts;

  dtkf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.is_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtkf_dp #(
    .ACC_BITS (ACC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/dtkf_dp.sv */
// datapath: character parser, decimal accumulator, normalizer and result register
`default_nettype none

module dtkf_dp import dtkf_pkg::*; #(
  parameter int ACC_BITS = DTKF_ACC_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire dtkf_in_t  in_data,
  input  wire dtkf_cmd_t cmd,
  output dtkf_sts_t      sts,
  output logic           out_valid,
  input  wire logic      out_stall,
  output dtkf_out_t      out_data
);

  localparam int PROD_BITS = ACC_BITS + 4;

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_INT   = 3'd1;
  localparam logic [2:0] PH_FRAC1 = 3'd2;
  localparam logic [2:0] PH_FRAC2 = 3'd3;
  localparam logic [2:0] PH_REST  = 3'd4;

  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic [2:0]          phase_r, phase_nxt;
  logic                neg_r, neg_nxt;
  logic                err_r, err_nxt;
  logic [EXP_BITS:0]   exp_r, exp_nxt;
  logic                out_valid_r, out_valid_nxt;
  dtkf_out_t           out_data_r, out_data_nxt;

  logic                 is_digit;
  logic [3:0]           digit;
  logic [3:0]           push_digit;
  logic [PROD_BITS-1:0] acc_ext;
  logic [PROD_BITS-1:0] prod;
  logic                 push_ovf;
  logic [ACC_BITS-1:0]  push_val;

  logic                 sat;
  logic [MANT_BITS-1:0] mant;
  logic [MANT_BITS-1:0] neg_mant;
  logic [EXP_BITS-1:0]  expo;
  logic [15:0]          word;

  // multiply by ten as shift-add, saturate on overflow
  always_comb begin
    is_digit   = (in_data.text_char >= CHAR_ZERO) && (in_data.text_char <= CHAR_NINE);
    digit      = is_digit ? 4'(in_data.text_char - CHAR_ZERO) : 4'd0;
    push_digit = cmd.pad ? 4'd0 : digit;
    acc_ext    = PROD_BITS'(acc_r);
    prod       = (acc_ext << 3) + (acc_ext << 1) + PROD_BITS'(push_digit);
    push_ovf   = |prod[PROD_BITS-1:ACC_BITS];
    push_val   = push_ovf ? '1 : prod[ACC_BITS-1:0];
  end

  always_comb begin
    sat      = exp_r > EXP_LIMIT;
    mant     = sat ? MANT_MAX : acc_r[MANT_BITS-1:0];
    expo     = sat ? EXP_TOP : exp_r[EXP_BITS-1:0];
    neg_mant = MANT_BITS'(NEG_BASE - {1'b0, mant});
    if (neg_r && (mant != '0)) begin
      word = {1'b1, expo, neg_mant};
    end else if (neg_r) begin
      // negative zero folds to plain zero
      word = '0;
    end else begin
      word = {1'b0, expo, mant};
    end
  end

  always_comb begin
    acc_nxt   = acc_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    err_nxt   = err_r;
    exp_nxt   = exp_r;
    priority if (cmd.clear) begin
      acc_nxt   = '0;
      phase_nxt = PH_FIRST;
      neg_nxt   = 1'b0;
      err_nxt   = 1'b0;
      exp_nxt   = '0;
    end else if (cmd.take) begin
      unique case (phase_r)
        PH_FIRST: begin
          if (is_digit) begin
            acc_nxt = push_val;
            err_nxt = err_r | push_ovf;
          end else if (in_data.text_char == CHAR_MINUS) begin
            neg_nxt = 1'b1;
          end
          phase_nxt = PH_INT;
        end
        PH_INT: begin
          if ((in_data.text_char == CHAR_DOT) || (in_data.text_char == CHAR_COMMA)) begin
            phase_nxt = PH_FRAC1;
          end else begin
            acc_nxt = push_val;
            err_nxt = err_r | push_ovf | !is_digit;
          end
        end
        PH_FRAC1, PH_FRAC2: begin
          acc_nxt   = push_val;
          err_nxt   = err_r | push_ovf | !is_digit;
          phase_nxt = phase_r + 3'd1;
        end
        default: begin
          // extra fraction digits are dropped
          phase_nxt = phase_r;
        end
      endcase
    end else if (cmd.pad) begin
      acc_nxt   = push_val;
      err_nxt   = err_r | push_ovf;
      phase_nxt = (phase_r <= PH_FRAC1) ? PH_FRAC2 : PH_REST;
    end else if (cmd.shift) begin
      acc_nxt = acc_r >> 1;
      exp_nxt = exp_r + 5'd1;
    end
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_data_nxt.float_word   = word;
      out_data_nxt.out_of_range = err_r | sat;
      out_valid_nxt             = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      phase_r     <= PH_FIRST;
      neg_r       <= 1'b0;
      err_r       <= 1'b0;
      exp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      err_r       <= err_nxt;
      exp_r       <= exp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    sts.pad_more  = phase_r <= PH_FRAC2;
    sts.norm_more = (acc_r > ACC_BITS'(MANT_MAX)) && (exp_r <= EXP_LIMIT);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hw/rtl/dtkf_ctrl.sv */
// controller: sequences character intake, zero padding, normalizing and result load
`default_nettype none

module dtkf_ctrl import dtkf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_stall,
  input  wire dtkf_sts_t sts,
  output dtkf_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_TAKE,
    S_PAD,
    S_NORM,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_TAKE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        // missing fraction digits count as zero
        cmd.pad = sts.pad_more;
        if (!sts.pad_more) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        cmd.shift = sts.norm_more;
        if (!sts.norm_more) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_TAKE;
        end
      end
      default: begin
        state_nxt = S_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_TAKE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dtkf_chk.sv */
// port-level checks for the encoder, bound to the top level
`default_nettype none

module dtkf_chk import dtkf_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire dtkf_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire dtkf_out_t out_data
);

  // a held result request keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the last character puts the parser into its finishing sequence
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.is_last |=> in_stall)
    else $error("input not stalled after last character");

  // a new result only appears from the finishing sequence
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without finishing sequence");

  // negative zero never leaves the block
  a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.float_word[15] |-> out_data.float_word[10:0] != 11'd0)
    else $error("negative result with zero mantissa");

endmodule

bind decimal_text_to_knx_float16 dtkf_chk u_dtkf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
